// ===== rtl/bitmap_to_page_column_bytes_macros.svh =====
// ----------------------------------------------------------------------------
// bitmap_to_page_column_bytes_macros
// assertion macros shared by the checker of the bitmap to page byte block
// ----------------------------------------------------------------------------
`ifndef BITMAP_TO_PAGE_COLUMN_BYTES_MACROS_SVH
`define BITMAP_TO_PAGE_COLUMN_BYTES_MACROS_SVH

// property checked outside reset
`define BPC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bpc assertion failed");

// property checked during reset as well
`define BPC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bpc assertion failed");

`endif

// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// shared constants and types of the bitmap to page byte block
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_PAGES_DEF   = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 8'd1;

  localparam logic [4:0] PAGE_COUNT_RST   = 5'd8;
  localparam logic [8:0] COLUMN_COUNT_RST = 9'd128;

  localparam logic [2:0] ROW_FIRST = 3'd0;
  localparam logic [2:0] ROW_LAST  = 3'd7;

  typedef logic [6:0] strip_t;

endpackage

// ===== rtl/bpc_pos.sv =====
// ----------------------------------------------------------------------------
// bpc_pos
// pixel position tracker: column, row within page and page counters
// ----------------------------------------------------------------------------
module bpc_pos #(
  parameter int MAX_COLUMNS = bpc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_PAGES   = bpc_pkg::MAX_PAGES_DEF,
  localparam int COL_W  = $clog2(MAX_COLUMNS),
  localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              advance,
  input  logic [4:0]        page_count,
  input  logic [8:0]        column_count,
  output logic [COL_W-1:0]  col,
  output logic [2:0]        row,
  output logic [PAGE_W-1:0] page,
  output logic              frame_last
);
  import bpc_pkg::*;

  localparam int CW = COL_W + 1;
  localparam int PW = PAGE_W + 1;

  logic [CW-1:0] eff_cols;
  logic [PW-1:0] eff_pages;
  logic          col_last;
  logic          page_last;

  always_comb begin
    if (column_count == 9'd0) begin
      eff_cols = CW'(1);
    end else if (32'(column_count) > MAX_COLUMNS) begin
      eff_cols = CW'(MAX_COLUMNS);
    end else begin
      eff_cols = CW'(column_count);
    end
    if (page_count == 5'd0) begin
      eff_pages = PW'(1);
    end else if (32'(page_count) > MAX_PAGES) begin
      eff_pages = PW'(MAX_PAGES);
    end else begin
      eff_pages = PW'(page_count);
    end
  end

  assign col_last   = (CW'(col) + CW'(1)) >= eff_cols;
  assign page_last  = (PW'(page) + PW'(1)) >= eff_pages;
  assign frame_last = col_last && page_last;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col  <= '0;
      row  <= ROW_FIRST;
      page <= '0;
    end else if (advance) begin
      if (col_last) begin
        col <= '0;
        if (row == ROW_LAST) begin
          row  <= ROW_FIRST;
          page <= page_last ? '0 : page + PAGE_W'(1);
        end else begin
          row <= row + 3'd1;
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/bpc_strip.sv =====
// ----------------------------------------------------------------------------
// bpc_strip
// column strip store with read-modify-write stage and output register
// ----------------------------------------------------------------------------
module bpc_strip #(
  parameter int MAX_COLUMNS = bpc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_PAGES   = bpc_pkg::MAX_PAGES_DEF,
  localparam int COL_W  = $clog2(MAX_COLUMNS),
  localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            pixel,
  input  logic [COL_W-1:0]                col,
  input  logic [2:0]                      row,
  input  logic [PAGE_W-1:0]               page,
  input  logic                            frame_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bpc_pkg::OUT_DATA_W-1:0]  out_data,
  output logic                            out_last
);
  import bpc_pkg::*;

  strip_t mem [MAX_COLUMNS];

  logic              s1_valid;
  logic              s1_pix;
  logic [COL_W-1:0]  s1_col;
  logic [2:0]        s1_row;
  logic [PAGE_W-1:0] s1_page;
  logic              s1_last;
  strip_t            rdata;
  logic              fwd_hit;
  strip_t            fwd_data;

  strip_t base;
  strip_t new_entry;
  logic   is_emit;
  logic   retire;
  logic   wr_en;
  logic   accept;

  assign is_emit   = (s1_row == ROW_LAST);
  assign base      = (s1_row == ROW_FIRST) ? '0 : (fwd_hit ? fwd_data : rdata);
  assign new_entry = (base & ~(strip_t'(1) << s1_row)) | (strip_t'(s1_pix) << s1_row);
  assign retire    = s1_valid && (!is_emit || !out_valid || out_ready);
  assign wr_en     = retire && !is_emit;
  assign in_ready  = !s1_valid || retire;
  assign accept    = in_valid && in_ready;

  // strip store, read before write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_col] <= new_entry;
    end
    if (accept) begin
      rdata <= mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        // same column written on this edge: read data is stale
        fwd_hit  <= wr_en && (s1_col == col);
      end else if (retire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pixel;
      s1_col   <= col;
      s1_row   <= row;
      s1_page  <= page;
      s1_last  <= frame_last;
      fwd_data <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (retire && is_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && is_emit) begin
      out_data <= {4'b0000, 8'(s1_col), 4'(s1_page), s1_pix, base};
      out_last <= s1_last;
    end
  end

endmodule

// ===== rtl/bitmap_to_page_column_bytes.sv =====
// ----------------------------------------------------------------------------
// bitmap_to_page_column_bytes
// repacks a row-major one-bit pixel stream into vertical page column bytes
// ----------------------------------------------------------------------------
// Takes one pixel per clock, sustained, with back-pressure only from the
// output side. Each pixel goes through a single read-modify-write of its
// column entry in the strip store (one read and one write port, with a
// bypass for back-to-back beats on the same column); pixels of row 7 leave
// as a byte via the s1 and output registers. A count register write restarts
// the frame at page 0, row 0, column 0. The store needs no clearing
// after reset: each entry is rewritten on row 0 of every page before use.
module bitmap_to_page_column_bytes #(
  parameter int MAX_COLUMNS = bpc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_PAGES   = bpc_pkg::MAX_PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [0] pixel, [7:1] zero
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] column_byte, [11:8] page_index, [19:12] column_index, [23:20] zero
  output logic [bpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,   // frame_end
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bpc_pkg::*;

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  logic [4:0]        page_count;
  logic [8:0]        column_count;
  logic              cfg_write;
  logic              restart;
  logic              accept;
  logic [COL_W-1:0]  col;
  logic [2:0]        row;
  logic [PAGE_W-1:0] page;
  logic              frame_last;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write &&
                     ((cfg_index == REG_PAGE_COUNT) || (cfg_index == REG_COLUMN_COUNT));
  assign accept    = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count   <= PAGE_COUNT_RST;
      column_count <= COLUMN_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PAGE_COUNT:   page_count   <= cfg_data[4:0];
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  bpc_pos #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_PAGES   (MAX_PAGES)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .advance      (accept),
    .page_count   (page_count),
    .column_count (column_count),
    .col          (col),
    .row          (row),
    .page         (page),
    .frame_last   (frame_last)
  );

  bpc_strip #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_PAGES   (MAX_PAGES)
  ) u_strip (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .pixel      (s_axis_tdata[0]),
    .col        (col),
    .row        (row),
    .page       (page),
    .frame_last (frame_last),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

// ===== rtl/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// bpc_checker
// port-level checks of the bitmap to page byte block, bound to the top level
// ----------------------------------------------------------------------------
`include "bitmap_to_page_column_bytes_macros.svh"

module bpc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            cfg_ready
);
  import bpc_pkg::*;

  // stalled output beat holds
  `BPC_ASSERT(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))

  // no output beat straight after reset
  `BPC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_axis_tvalid)

  // padding bits of an output beat are zero
  `BPC_ASSERT(a_pad_zero, clk, rst, m_axis_tvalid |-> (m_axis_tdata[23:20] == 4'd0))

  // register port never stalls
  `BPC_ASSERT(a_cfg_ready, clk, rst, cfg_ready)

endmodule

bind bitmap_to_page_column_bytes bpc_checker u_bpc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready     (cfg_ready)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bitmap to page column byte repacker
// ----------------------------------------------------------------------------
// Streams one-bit pixels into the block and keeps its own copy of the column
// strips, row, column and page counters. Every pixel of a page's eighth row
// yields an expected byte, which is compared field by field with the output
// beats. Covers the reset geometry, clamping of out-of-range registers,
// frame restart on a register write, writes to unknown indexes, and random
// geometries and pixels with random gaps and back-pressure on both sides.
module tb_top;
  import bpc_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_PIXELS = 150;
  localparam int RANDOM_BYTES = 12;
  localparam int STEADY_LEN = 120;
  localparam int PHASE_CAP = 48;

  typedef struct {
    logic [7:0] column_byte;
    logic [3:0] page;
    logic [7:0] column;
    logic       frame_end;
  } page_byte_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // expected bytes and the repacker state they come from
  page_byte_t  pending_bytes[$];
  strip_t      strip_mem [MAX_COLUMNS_DEF];
  logic [2:0]  row_pos;
  int unsigned col_pos;
  int unsigned page_pos;
  logic [4:0]  page_reg;
  logic [8:0]  column_reg;

  int errors;
  int pixels_sent;
  int bytes_checked;
  int quiet_cycles;
  bit steady;

  bitmap_to_page_column_bytes u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_pages();
    if (page_reg == 0) return 1;
    if (page_reg > MAX_PAGES_DEF) return MAX_PAGES_DEF;
    return 32'(page_reg);
  endfunction

  function automatic int unsigned eff_columns();
    if (column_reg == 0) return 1;
    if (column_reg > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return 32'(column_reg);
  endfunction

  task automatic restart_frame();
    row_pos = ROW_FIRST;
    col_pos = 0;
    page_pos = 0;
  endtask

  task automatic update_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_PAGE_COUNT) begin
      page_reg = val[4:0];
      restart_frame();
    end else if (idx == REG_COLUMN_COUNT) begin
      column_reg = val;
      restart_frame();
    end
  endtask

  task automatic predict_pixel(input bit pix);
    int unsigned cols;
    int unsigned pages;
    page_byte_t  b;
    cols = eff_columns();
    pages = eff_pages();
    if (row_pos != ROW_LAST) begin
      if (row_pos == ROW_FIRST) strip_mem[col_pos[7:0]] = '0;
      strip_mem[col_pos[7:0]][row_pos] = pix;
    end else begin
      b.column_byte = {pix, strip_mem[col_pos[7:0]]};
      b.page = page_pos[3:0];
      b.column = col_pos[7:0];
      b.frame_end = (page_pos + 1 >= pages) && (col_pos + 1 >= cols);
      pending_bytes.push_back(b);
    end
    // step to the next pixel position
    if (col_pos + 1 >= cols) begin
      col_pos = 0;
      if (row_pos == ROW_LAST) begin
        row_pos = ROW_FIRST;
        page_pos = (page_pos + 1 >= pages) ? 0 : page_pos + 1;
      end else begin
        row_pos = row_pos + 3'd1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    errors++;
  endtask

  task automatic send_pixel(input bit pix);
    while (!steady && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, pix};
    predict_pixel(pix);
    do @(posedge clk); while (!s_axis_tready);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) send_pixel(1'($urandom_range(0, 1)));
  endtask

  // let outstanding bytes drain and the pipeline settle
  task automatic wait_for_quiet();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    update_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] pages,
                              input logic [CFG_DATA_W-1:0] cols);
    wait_for_quiet();
    write_register(REG_PAGE_COUNT, pages);
    write_register(REG_COLUMN_COUNT, cols);
  endtask

  // first row of the reset geometry, 128 columns, no beat may appear
  task automatic test_reset_geometry();
    send_random_pixels(128);
  endtask

  task automatic test_directed_patterns();
    set_geometry(9'd1, 9'd2);
    // column 0 all set, column 1 all clear
    for (int r = 0; r < 8; r++) begin
      send_pixel(1'b1);
      send_pixel(1'b0);
    end
    wait_for_quiet();
    write_register(REG_COLUMN_COUNT, 9'd1);
    for (int r = 0; r < 8; r++) send_pixel(r % 2 == 0);
  endtask

  task automatic test_register_limits();
    // zero means one page of one column
    set_geometry(9'd0, 9'd0);
    send_random_pixels(16);
    // page count above range, upper data bits set
    set_geometry(9'h1ff, 9'd1);
    send_random_pixels(16 * 8 + 8);
    // column count above range clamps to the widest row
    set_geometry(9'd1, 9'h1ff);
    send_random_pixels(16);
  endtask

  task automatic test_unknown_index();
    set_geometry(9'd2, 9'd3);
    send_random_pixels(10);
    wait_for_quiet();
    write_register(8'd2, 9'($urandom_range(0, 511)));
    write_register(8'hff, 9'($urandom_range(0, 511)));
    write_register(8'($urandom_range(3, 254)), 9'($urandom_range(0, 511)));
    send_random_pixels(38);
  endtask

  task automatic test_frame_restart();
    set_geometry(9'd2, 9'd3);
    send_random_pixels(30);
    wait_for_quiet();
    write_register(REG_COLUMN_COUNT, 9'd3);
    send_random_pixels(29);
    wait_for_quiet();
    write_register(REG_PAGE_COUNT, 9'd2);
    send_random_pixels(48);
  endtask

  task automatic test_random_geometry();
    int          phase;
    int          first_pixel;
    int          first_byte;
    int unsigned strip_len;
    int unsigned len;
    int unsigned kind;
    logic [CFG_DATA_W-1:0] pages;
    logic [CFG_DATA_W-1:0] cols;
    phase = 0;
    first_pixel = pixels_sent;
    first_byte = bytes_checked;
    while (pixels_sent - first_pixel < RANDOM_PIXELS ||
           bytes_checked - first_byte < RANDOM_BYTES) begin
      steady = (phase == 2);
      kind = $urandom_range(0, 7);
      if (kind == 0) begin
        pages = 9'($urandom_range(0, 511));
        cols = 9'($urandom_range(0, 511));
      end else begin
        pages = 9'($urandom_range(1, 4));
        cols = 9'($urandom_range(1, 12));
      end
      wait_for_quiet();
      if ($urandom_range(0, 5) == 0)
        write_register(8'($urandom_range(2, 255)), 9'($urandom_range(0, 511)));
      if (kind == 1) begin
        write_register(REG_COLUMN_COUNT, cols);
      end else if (kind == 2) begin
        write_register(REG_PAGE_COUNT, pages);
      end else if (kind == 3) begin
        write_register(REG_COLUMN_COUNT, cols);
        write_register(REG_PAGE_COUNT, pages);
      end else begin
        write_register(REG_PAGE_COUNT, pages);
        write_register(REG_COLUMN_COUNT, cols);
      end
      strip_len = 8 * eff_columns();
      len = $urandom_range(strip_len, 2 * strip_len);
      if (len > PHASE_CAP) len = PHASE_CAP;
      // one long stretch with no gaps on either side
      if (steady) len = STEADY_LEN;
      send_random_pixels(len);
      phase++;
    end
    steady = 1'b0;
  endtask

  // output side back-pressure
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin : check_bytes
    page_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected beat", 32'(m_axis_tdata), 0);
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata[7:0] !== want.column_byte)
          report_mismatch("column_byte", 32'(m_axis_tdata[7:0]), 32'(want.column_byte));
        if (m_axis_tdata[11:8] !== want.page)
          report_mismatch("page_index", 32'(m_axis_tdata[11:8]), 32'(want.page));
        if (m_axis_tdata[19:12] !== want.column)
          report_mismatch("column_index", 32'(m_axis_tdata[19:12]), 32'(want.column));
        if (m_axis_tlast !== want.frame_end)
          report_mismatch("frame_end", 32'(m_axis_tlast), 32'(want.frame_end));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    pixels_sent = 0;
    bytes_checked = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    foreach (strip_mem[i]) strip_mem[i] = '0;
    page_reg = PAGE_COUNT_RST;
    column_reg = COLUMN_COUNT_RST;
    restart_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_geometry();
    test_directed_patterns();
    test_register_limits();
    test_unknown_index();
    test_frame_restart();
    test_random_geometry();

    wait_for_quiet();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
